// ===== src/u8c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8c_pkg
// shared types and constants for the utf-8 to surrogate utf-8 rewriter
// ----------------------------------------------------------------------------
package u8c_pkg;

    // longest source string; sets the output byte count cap
    localparam int unsigned MAX_IN_BYTES = 65535;
    localparam int unsigned CNT_W        = 17;
    localparam logic [CNT_W-1:0] OUT_CAP =
        CNT_W'(MAX_IN_BYTES + MAX_IN_BYTES / 2);

    // most result bytes one input byte can cause
    localparam int unsigned BURST_MAX = 6;
    localparam int unsigned BURST_W   = 3;

    // lead byte of a four-byte sequence
    localparam logic [7:0] LEAD_MASK = 8'hf8;
    localparam logic [7:0] LEAD_CODE = 8'hf0;

    // result bytes of one input byte, lowest index goes out first
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_W-1:0]        n;
    } t_burst;

    // update of the lead-group holding register
    typedef struct packed {
        logic       wr;
        logic [1:0] cnt;
    } t_hold;

endpackage

// ===== src/u8c_xlate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8c_xlate
// per-byte rewrite: holds four-byte groups and turns them into two
// three-byte surrogate sequences, everything else passes through
// ----------------------------------------------------------------------------
module u8c_xlate
    import u8c_pkg::*;
(
    input  logic [1:0]      i_held_cnt,
    input  logic [2:0][7:0] i_held,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output t_burst          o_burst,
    output t_hold           o_hold
);

    logic [20:0] w_cp;
    logic [31:0] w_v;
    logic [31:0] w_hi;
    logic [15:0] w_lo;

    // code point and surrogate halves, 32-bit wrap as in software
    assign w_cp = {i_held[0][2:0], i_held[1][5:0], i_held[2][5:0], i_byte[5:0]};
    assign w_v  = {11'd0, w_cp} - 32'h0001_0000;
    assign w_hi = 32'h0000_d800 + {10'd0, w_v[31:10]};
    assign w_lo = 16'hdc00 + {6'd0, w_v[9:0]};

    always_comb begin
        o_burst.bytes = '0;
        o_burst.n     = '0;
        o_hold.wr     = 1'b0;
        o_hold.cnt    = 2'd0;
        case (i_held_cnt)
            2'd0: begin
                if (((i_byte & LEAD_MASK) == LEAD_CODE) && !i_end) begin
                    o_hold.wr  = 1'b1;
                    o_hold.cnt = 2'd1;
                end else begin
                    o_burst.bytes[0] = i_byte;
                    o_burst.n        = BURST_W'(1);
                end
            end
            2'd1: begin
                if (i_end) begin
                    // group cut short: flush raw
                    o_burst.bytes[0] = i_held[0];
                    o_burst.bytes[1] = i_byte;
                    o_burst.n        = BURST_W'(2);
                end else begin
                    o_hold.wr  = 1'b1;
                    o_hold.cnt = 2'd2;
                end
            end
            2'd2: begin
                if (i_end) begin
                    o_burst.bytes[0] = i_held[0];
                    o_burst.bytes[1] = i_held[1];
                    o_burst.bytes[2] = i_byte;
                    o_burst.n        = BURST_W'(3);
                end else begin
                    o_hold.wr  = 1'b1;
                    o_hold.cnt = 2'd3;
                end
            end
            default: begin
                // fourth byte of a group
                o_burst.bytes[0] = 8'he0 | w_hi[19:12];
                o_burst.bytes[1] = 8'h80 | {2'b00, w_hi[11:6]};
                o_burst.bytes[2] = 8'h80 | {2'b00, w_hi[5:0]};
                o_burst.bytes[3] = 8'he0 | {4'h0, w_lo[15:12]};
                o_burst.bytes[4] = 8'h80 | {2'b00, w_lo[11:6]};
                o_burst.bytes[5] = 8'h80 | {2'b00, w_lo[5:0]};
                o_burst.n        = BURST_W'(BURST_MAX);
            end
        endcase
    end

endmodule

// ===== src/utf8_to_surrogate_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_surrogate_utf8
// streaming rewrite of utf-8 into cesu-8: four-byte sequences become two
// three-byte surrogate sequences, all other bytes pass through
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                tuser     tlast
//  s_axis    in         [7:0] source byte                    -         string end
//  m_axis    out        [7:0] result byte, [24:8] out count  run last  string last
//
//  an input byte is taken in the cycle it arrives whenever the result buffer
//  is empty or its last byte leaves in that cycle; pass-through bytes run at
//  one per cycle while the output does not stall. a byte causing more than
//  one result holds the input until its last result leaves, and held group
//  bytes give none; the one-byte output port sets the sustained rate. results
//  are registered and appear in the cycle after their byte is taken.
//  i_rst_n (synchronous, active low) clears the group holder, the result
//  buffer and the byte count. output stalls simply hold the buffer.
// ----------------------------------------------------------------------------
module utf8_to_surrogate_utf8
    import u8c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [24:8] out_count
    output logic        m_axis_tuser,   // run_last
    output logic        m_axis_tlast    // string_last
);

    // group holder: lead byte and followers, payload needs no reset
    logic [2:0][7:0]           r_held;
    logic [1:0]                r_held_cnt;
    logic [1:0]                n_held_cnt;

    // result buffer, shifts down one byte per output transaction
    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [BURST_MAX-1:0][7:0] n_bytes;
    logic [BURST_W-1:0]        r_left;
    logic [BURST_W-1:0]        n_left;
    logic                      r_end;

    // output bytes of the current string so far
    logic [CNT_W-1:0]          r_emit;
    logic [CNT_W-1:0]          n_emit;
    logic [CNT_W-1:0]          w_count;

    logic                      w_s_acc;
    logic                      w_m_acc;
    logic                      w_run_last;
    t_burst                    w_burst;
    t_hold                     w_hold;

    u8c_xlate u_xlate (
        .i_held_cnt (r_held_cnt),
        .i_held     (r_held),
        .i_byte     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .o_burst    (w_burst),
        .o_hold     (w_hold)
    );

    // take a new byte when the buffer is empty or drains in this cycle
    assign s_axis_tready = (r_left == '0) ||
                           ((r_left == BURST_W'(1)) && m_axis_tready);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = m_axis_tvalid && m_axis_tready;

    assign w_run_last    = (r_left == BURST_W'(1));
    assign w_count       = (r_emit == OUT_CAP) ? OUT_CAP : r_emit + CNT_W'(1);

    assign m_axis_tvalid = (r_left != '0);
    assign m_axis_tdata  = {7'd0, w_count, r_bytes[0]};
    assign m_axis_tuser  = w_run_last;
    assign m_axis_tlast  = w_run_last && r_end;

    always_comb begin
        n_held_cnt = r_held_cnt;
        n_bytes    = r_bytes;
        n_left     = r_left;
        n_emit     = r_emit;
        if (w_s_acc) begin
            n_held_cnt = w_hold.cnt;
            n_bytes    = w_burst.bytes;
            n_left     = w_burst.n;
        end else if (w_m_acc) begin
            n_bytes    = {8'h00, r_bytes[BURST_MAX-1:1]};
            n_left     = r_left - BURST_W'(1);
        end
        if (w_m_acc) begin
            // count restarts after the final byte of a string
            n_emit = m_axis_tlast ? '0 : w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
            r_left     <= '0;
            r_emit     <= '0;
        end else begin
            r_held_cnt <= n_held_cnt;
            r_left     <= n_left;
            r_emit     <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (w_s_acc) begin
            r_end <= s_axis_tlast;
            if (w_hold.wr) begin
                r_held[r_held_cnt] <= s_axis_tdata;
            end
        end
    end

    // string end never leaves bytes held
    a_end_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && s_axis_tlast) |=> (r_held_cnt == 2'd0))
        else $error("group bytes held across string end");

    // string end only on the last byte of a run
    a_last_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("string last without run last");

    // a held byte produces no results
    a_hold_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_hold.wr) |=> !m_axis_tvalid)
        else $error("results after a held byte");

    // count never passes the cap and is never zero on a result
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_count != '0) && (w_count <= OUT_CAP)))
        else $error("output count out of range");

endmodule

// ===== tb/sv/utf8_to_surrogate_utf8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_surrogate_utf8_checker
// watches both stream channels, predicts the cesu-8 result bytes of every
// source byte taken in, and compares them in order with what comes out
// ----------------------------------------------------------------------------
module utf8_to_surrogate_utf8_checker
    import u8c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] in_byte
    input  logic        i_in_last,    // string_end
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // [7:0] out_byte, [24:8] out_count
    input  logic        i_out_user,   // run_last
    input  logic        i_out_last,   // string_last
    output int unsigned o_mismatches,
    output int unsigned o_pending,
    output int unsigned o_results,
    output int unsigned o_groups,
    output int unsigned o_cut_groups,
    output logic        o_cap_hit
);

    localparam int unsigned SHOW_MAX = 20;

    typedef struct packed {
        logic [7:0]       data;
        logic             run_last;
        logic             str_last;
        logic [CNT_W-1:0] count;
    } t_cesu_byte;

    t_cesu_byte       due_bytes [$];
    t_cesu_byte       want;
    logic [7:0]       held [3];
    logic [1:0]       held_cnt;
    logic [CNT_W-1:0] str_count;

    // three-byte encoding of one 16-bit surrogate, first byte lowest
    function automatic logic [23:0] surrogate_bytes(input logic [31:0] unit);
        logic [31:0] top;
        top = 32'he0 | (unit >> 12);
        return {8'h80 | {2'b00, unit[5:0]}, 8'h80 | {2'b00, unit[11:6]}, top[7:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (o_mismatches < SHOW_MAX)
            $display("[%0t] result %0d: %s got 0x%0h, predicted 0x%0h",
                     $time, o_results, what, got, exp_val);
        o_mismatches++;
    endtask

    task automatic rewrite_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  seq [6];
        int          n;
        logic [20:0] cp;
        logic [31:0] v;
        logic [23:0] hi_b;
        logic [23:0] lo_b;
        t_cesu_byte  item;
        n = 0;
        if (held_cnt == 0) begin
            if ((b & LEAD_MASK) == LEAD_CODE && !fin) begin
                held[0]  = b;
                held_cnt = 1;
            end else begin
                seq[n] = b;
                n++;
            end
        end else if (held_cnt < 3) begin
            if (fin) begin
                // group cut short by string end: everything held goes out raw
                for (int k = 0; k < held_cnt; k++) begin
                    seq[n] = held[k];
                    n++;
                end
                seq[n] = b;
                n++;
                held_cnt = 0;
                o_cut_groups++;
            end else begin
                held[held_cnt] = b;
                held_cnt++;
            end
        end else begin
            cp   = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
            v    = 32'(cp) - 32'h10000;
            hi_b = surrogate_bytes(32'hd800 + (v >> 10));
            lo_b = surrogate_bytes(32'hdc00 + (v & 32'h3ff));
            for (int k = 0; k < 3; k++) begin
                seq[k]     = hi_b[8*k +: 8];
                seq[k + 3] = lo_b[8*k +: 8];
            end
            n        = 6;
            held_cnt = 0;
            o_groups++;
        end
        for (int k = 0; k < n; k++) begin
            if (str_count < OUT_CAP)
                str_count++;
            else
                o_cap_hit = 1'b1;
            item.data     = seq[k];
            item.run_last = (k == n - 1);
            item.str_last = (k == n - 1) && fin;
            item.count    = str_count;
            due_bytes.push_back(item);
        end
        if (fin) begin
            str_count = '0;
            held_cnt  = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_bytes.delete();
            held_cnt     = 0;
            str_count    = '0;
            o_mismatches = 0;
            o_results    = 0;
            o_groups     = 0;
            o_cut_groups = 0;
            o_cap_hit    = 1'b0;
        end else begin
            if (i_in_valid && i_in_ready)
                rewrite_byte(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (due_bytes.size() == 0) begin
                    report_mismatch("result with nothing due", i_out_data, 32'h0);
                end else begin
                    want = due_bytes.pop_front();
                    if (i_out_data[7:0] !== want.data)
                        report_mismatch("out_byte", 32'(i_out_data[7:0]),
                                        32'(want.data));
                    if (i_out_data[24:8] !== want.count)
                        report_mismatch("out_count", 32'(i_out_data[24:8]),
                                        32'(want.count));
                    if (i_out_user !== want.run_last)
                        report_mismatch("run_last", 32'(i_out_user),
                                        32'(want.run_last));
                    if (i_out_last !== want.str_last)
                        report_mismatch("string_last", 32'(i_out_last),
                                        32'(want.str_last));
                end
                o_results++;
            end
        end
        o_pending = due_bytes.size();
    end

endmodule

// ===== tb/sv/utf8_to_surrogate_utf8_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_surrogate_utf8_tb
// drives byte strings into the utf-8 to cesu-8 rewriter under random input
// bursts and output stalls; the checker beside the dut predicts every result
// ----------------------------------------------------------------------------
module utf8_to_surrogate_utf8_tb;
    import u8c_pkg::*;

    localparam int      CLK_HALF_NS  = 6;
    localparam int      RESET_CYCLES = 10;
    localparam int      RANDOM_ITEMS = 400;
    localparam int      HOLD_CYCLES  = 200;
    localparam int      HOLD_STRING  = 4;
    localparam int      DRAIN_STRING = 8;
    localparam longint  LIMIT_NS     = 64'd2_000_000;

    typedef enum logic {RX_OPEN, RX_CHOPPY} t_rx_mode;

    // directed strings, {string_end, byte}
    localparam logic [8:0] DIRECTED [25] = '{
        9'h000, 9'h0ff, 9'h1e0,             // plain bytes, extremes, string end
        9'h0f0, 9'h090, 9'h080, 9'h080,     // lowest supplementary code point
        9'h0f4, 9'h08f, 9'h0bf, 9'h0bf,     // highest valid code point
        9'h0f0, 9'h080, 9'h080, 9'h080,     // below 0x10000, wraps
        9'h0f7, 9'h0ff, 9'h0ff, 9'h1ff,     // above range, fourth byte ends string
        9'h1f3,                             // lone lead as final byte
        9'h0f1, 9'h180,                     // group cut after two bytes
        9'h0f2, 9'h081, 9'h182              // group cut after three bytes
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;    // string_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] out_byte, [24:8] out_count
    logic        m_axis_tuser;            // run_last
    logic        m_axis_tlast;            // string_last

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results;
    int unsigned groups;
    int unsigned cut_groups;
    logic        cap_hit;

    // sender pacing
    int unsigned burst_left   = 0;
    bit          gaps_on      = 1'b1;
    int unsigned items_sent   = 0;
    int unsigned strings_sent = 0;

    // receiver pacing; a toggle of hold_req asks for one long hold-off
    t_rx_mode    rx_mode      = RX_CHOPPY;
    logic        hold_req     = 1'b0;
    logic        hold_seen    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    utf8_to_surrogate_utf8 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_to_surrogate_utf8_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_groups     (groups),
        .o_cut_groups (cut_groups),
        .o_cap_hit    (cap_hit)
    );

    // receiver: open, or short random stalls; a hold-off request wins over both
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= hold_req;
            hold_left     <= 0;
            stall_left    <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_mode == RX_OPEN) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            // start a stall of random length
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // offers one source byte and returns right after the edge that takes it;
    // between bursts valid drops for a random gap
    task automatic send_byte(input logic [7:0] b, input logic fin);
        logic took;
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        // tready is settled mid-cycle, so the handshake is read at the falling edge
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        if (burst_left != 0)
            burst_left--;
        items_sent++;
        if (fin)
            strings_sent++;
    endtask

    // sender pauses until every predicted byte has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0]  str_bytes [$];
        logic [7:0]  b;
        logic        group_tail;
        int unsigned target;
        int unsigned random_items;
        int unsigned str_idx;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, range edges and the cut-short cases
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // random strings, mostly four-byte groups with random content
        random_items = 0;
        str_idx      = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (str_idx == DRAIN_STRING || $urandom_range(0, 7) == 0)
                wait_drained();
            rx_mode <= ($urandom_range(0, 3) == 0) ? RX_OPEN : RX_CHOPPY;
            gaps_on = ($urandom_range(0, 4) != 0);
            if (str_idx == HOLD_STRING) begin
                // receiver holds off while this string keeps coming back to back
                hold_req <= ~hold_req;
                gaps_on = 1'b0;
            end
            target = (str_idx == HOLD_STRING) ? 24 : $urandom_range(1, 24);
            str_bytes.delete();
            group_tail = 1'b0;
            while (str_bytes.size() < target) begin
                case ($urandom_range(0, 9)) inside
                    [0:4]: begin
                        // lead plus three bytes, mostly continuation bytes
                        str_bytes.push_back(LEAD_CODE | 8'($urandom_range(0, 7)));
                        repeat (3)
                            str_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                8'($urandom) : (8'h80 | 8'($urandom_range(0, 63))));
                        group_tail = 1'b1;
                    end
                    [5:7]: begin
                        // any byte that is not a lead
                        b = 8'($urandom);
                        if ((b & LEAD_MASK) == LEAD_CODE)
                            b = b ^ 8'h08;
                        str_bytes.push_back(b);
                        group_tail = 1'b0;
                    end
                    default: begin
                        // raw noise, may start a group that swallows what follows
                        str_bytes.push_back(8'($urandom));
                        group_tail = 1'b0;
                    end
                endcase
            end
            // now and then the string ends inside its last group
            if (group_tail && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    void'(str_bytes.pop_back());
            foreach (str_bytes[i])
                send_byte(str_bytes[i], i == str_bytes.size() - 1);
            random_items += str_bytes.size();
            str_idx++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d source bytes in %0d strings: %0d groups rewritten, %0d cut short",
                 items_sent, strings_sent, groups, cut_groups);
        $display("%0d result bytes compared, output count cap %s",
                 results, cap_hit ? "reached" : "not reached");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // guard against a hung handshake
    initial begin : watchdog
        #(LIMIT_NS);
        $display("run timed out, %0d result bytes still due", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
